[src/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg: shared definitions for the double-ended queue
// Operation codes, status codes, field widths and the default depth.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int FUNC_W    = 3;
  localparam int DATA_W    = 32;
  localparam int STAT_W    = 2;
  localparam int OCC_W     = 6;

  localparam logic [FUNC_W-1:0] F_INS_FRONT = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] F_INS_BACK  = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] F_DEL_FRONT = FUNC_W'(2);
  localparam logic [FUNC_W-1:0] F_DEL_BACK  = FUNC_W'(3);
  localparam logic [FUNC_W-1:0] F_READ_OUT  = FUNC_W'(4);

  localparam logic [STAT_W-1:0] ST_OK    = STAT_W'(0);
  localparam logic [STAT_W-1:0] ST_EMPTY = STAT_W'(1);
  localparam logic [STAT_W-1:0] ST_FULL  = STAT_W'(2);

endpackage

[src/double_ended_queue_top.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_top: bounded double-ended queue of signed words
// Circular entry memory with front index and entry count; insert and
// delete at either end, and read-out of all entries front to back.
//
//   channel   signals                                   direction
//   command   start, busy, func, item                   in (busy out)
//   result    strobe, value, status, occupancy,         out
//             last_of_run
//
// Insert and delete: result in the cycle after the transaction; busy stays
//   low, so a new command may follow every cycle.
// Read-out of n entries: busy in the READ state; n results on consecutive
//   cycles after the READ state and the registered memory read, one per read
//   of the single memory read port. Empty read-out: one result next cycle.
// Codes 5 to 7 give no result. Reset is synchronous and empties the queue.
// Results cannot be stalled; each is valid only in its strobe cycle.
// ----------------------------------------------------------------------------
module double_ended_queue_top import dq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [FUNC_W-1:0]        func,
  input  logic signed [DATA_W-1:0] item,
  output logic                     strobe,
  output logic signed [DATA_W-1:0] value,
  output logic [STAT_W-1:0]        status,
  output logic [OCC_W-1:0]         occupancy,
  output logic                     last_of_run
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  dq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .func        (func),
    .item        (item),
    .busy        (busy),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .strobe      (strobe),
    .value       (value),
    .status      (status),
    .occupancy   (occupancy),
    .last_of_run (last_of_run)
  );

  dq_store #(.DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[src/dq_store.sv]
// ----------------------------------------------------------------------------
// dq_store: entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dq_store import dq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic signed [DATA_W-1:0]               wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic signed [DATA_W-1:0]               rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/dq_ctrl.sv]
// ----------------------------------------------------------------------------
// dq_ctrl: queue sequencer
// Holds front index and entry count, computes insert slots and front steps
// with separate index adders, and steps the read pointer through a read-out.
// ----------------------------------------------------------------------------
module dq_ctrl import dq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic [FUNC_W-1:0]                      func,
  input  logic signed [DATA_W-1:0]               item,
  output logic                                   busy,
  output logic                                   mem_we,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_waddr,
  output logic signed [DATA_W-1:0]               mem_wdata,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] mem_raddr,
  input  logic signed [DATA_W-1:0]               mem_rdata,
  output logic                                   strobe,
  output logic signed [DATA_W-1:0]               value,
  output logic [STAT_W-1:0]                      status,
  output logic [OCC_W-1:0]                       occupancy,
  output logic                                   last_of_run
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;

  typedef enum logic {IDLE, READ} state_t;

  state_t          state;
  logic [AW-1:0]   front;
  logic [CW-1:0]   count;
  logic [AW-1:0]   ptr;
  logic [CW-1:0]   idx;
  logic            rd_sel;

  logic            accept;
  logic            full;
  logic            empty;
  logic            last_rd;
  logic [AW-1:0]   front_dec;
  logic [AW-1:0]   front_inc;
  logic [AW-1:0]   ptr_inc;
  logic [SW-1:0]   back_sum;
  logic [AW-1:0]   back_slot;

  always_comb begin
    accept    = start && (state == IDLE);
    full      = (count == CW'(DEPTH));
    empty     = (count == '0);
    last_rd   = (CW'(idx + 1'b1) == count);
    front_dec = (front == '0) ? AW'(DEPTH - 1) : AW'(front - 1'b1);
    front_inc = (front == AW'(DEPTH - 1)) ? '0 : AW'(front + 1'b1);
    ptr_inc   = (ptr == AW'(DEPTH - 1)) ? '0 : AW'(ptr + 1'b1);
    back_sum  = SW'(front) + SW'(count);
    back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
  end

  always_comb begin
    mem_we    = accept && !full && ((func == F_INS_FRONT) || (func == F_INS_BACK));
    mem_waddr = (func == F_INS_FRONT) ? front_dec : back_slot;
    mem_wdata = item;
    mem_raddr = ptr;
    busy      = (state == READ);
    value     = rd_sel ? mem_rdata : '0;
    occupancy = OCC_W'(count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      front  <= '0;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      rd_sel <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            unique case (func)
              F_INS_FRONT, F_INS_BACK: begin
                strobe      <= 1'b1;
                last_of_run <= 1'b1;
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  status <= ST_OK;
                  count  <= CW'(count + 1'b1);
                  if (func == F_INS_FRONT) begin
                    front <= front_dec;
                  end
                end
              end
              F_DEL_FRONT, F_DEL_BACK: begin
                strobe      <= 1'b1;
                last_of_run <= 1'b1;
                if (empty) begin
                  status <= ST_EMPTY;
                end else begin
                  status <= ST_OK;
                  count  <= CW'(count - 1'b1);
                  if (func == F_DEL_FRONT) begin
                    front <= front_inc;
                  end
                end
              end
              F_READ_OUT: begin
                if (empty) begin
                  strobe      <= 1'b1;
                  last_of_run <= 1'b1;
                  status      <= ST_EMPTY;
                end else begin
                  state <= READ;
                  ptr   <= front;
                  idx   <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        READ: begin
          strobe      <= 1'b1;
          rd_sel      <= 1'b1;
          status      <= ST_OK;
          last_of_run <= last_rd;
          ptr         <= ptr_inc;
          idx         <= CW'(idx + 1'b1);
          if (last_rd) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == READ) |-> (count != '0))
    else $error("read-out running on empty queue");

  a_read_strobe: assert property (@(posedge clk) disable iff (rst)
    (state == READ) |=> strobe)
    else $error("read-out step gave no result");

  a_op_result: assert property (@(posedge clk) disable iff (rst)
    (accept && ((func == F_INS_FRONT) || (func == F_INS_BACK) ||
                (func == F_DEL_FRONT) || (func == F_DEL_BACK))) |=> strobe)
    else $error("insert or delete gave no result");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_of_run) |-> !busy)
    else $error("busy after final result of transaction");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (strobe && (status == ST_FULL)) |-> (count == CW'(DEPTH)))
    else $error("full status with free entries");

endmodule
